[src/drfe_pkg.sv]
// Package with byte codes, register indexes and defaults for the delimited row field extractor.
package drfe_pkg;

  localparam int MAX_TEXT_BYTES_DEFAULT = 10;
  localparam int PATTERN_BYTES = 10;

  localparam logic [7:0] PIPE_BYTE = 8'h7C;
  localparam logic [7:0] NEWLINE_BYTE = 8'h0A;
  localparam logic [7:0] ZERO_BYTE = 8'h30;
  localparam logic [7:0] NINE_BYTE = 8'h39;

  localparam int CFG_INDEX_WIDTH = 3;
  localparam int CFG_DATA_WIDTH = 64;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_TARGET_COLUMN = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_FIELD_MODE = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_PATTERN_LOW = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_PATTERN_HIGH = 3'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_PATTERN_LENGTH = 3'd4;

  localparam logic [3:0] TARGET_COLUMN_RESET = 4'd1;

endpackage

[src/delimited_row_field_extract_top.sv]
// A result beat appears in the output register in the cycle after its closing pipe beat is accepted.
// Throughput: one input byte per cycle; the input stalls only while a result waits unread.
// The row state and accumulators update in the same cycle a byte is accepted.
// Reset (rst, synchronous) clears the row state, empties the output register and
// returns the registers to target column 1, numeric mode and an empty compare text.
module delimited_row_field_extract_top #(
  parameter int MAX_TEXT_BYTES = drfe_pkg::MAX_TEXT_BYTES_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [drfe_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [drfe_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [7:0]                           data_byte,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [31:0]                          row_key,
  output logic [31:0]                          field_value,
  output logic                                 text_match,
  output logic                                 bad_digit
);

  localparam int CW = $clog2(MAX_TEXT_BYTES + 2);

  logic [3:0]  target_column;
  logic        field_mode;
  logic [63:0] pattern_low_bytes;
  logic [15:0] pattern_high_bytes;
  logic [3:0]  pattern_length;

  logic          skipping_row, skipping_row_next;
  logic [3:0]    column_count, column_count_next;
  logic [31:0]   key_accumulator, key_accumulator_next;
  logic [31:0]   value_accumulator, value_accumulator_next;
  logic [CW-1:0] field_byte_count, field_byte_count_next;
  logic          still_matching, still_matching_next;
  logic          digit_error, digit_error_next;

  logic          accept;
  logic          emit;
  logic          is_pipe;
  logic          is_newline;
  logic          is_digit;
  logic [7:0]    digit;
  logic [7:0]    pattern_sel;
  logic [CW-1:0] len_eff;
  logic [79:0]   pattern_all;

  assign accept = in_valid && in_ready;
  assign in_ready = !out_valid || out_ready;
  assign is_pipe = (data_byte == drfe_pkg::PIPE_BYTE);
  assign is_newline = (data_byte == drfe_pkg::NEWLINE_BYTE);
  assign is_digit = (data_byte >= drfe_pkg::ZERO_BYTE) && (data_byte <= drfe_pkg::NINE_BYTE);
  assign digit = data_byte - drfe_pkg::ZERO_BYTE;
  assign pattern_all = {pattern_high_bytes, pattern_low_bytes};
  assign len_eff = (int'(pattern_length) > MAX_TEXT_BYTES) ? CW'(MAX_TEXT_BYTES)
                                                           : CW'(pattern_length);
  assign emit = accept && !skipping_row && is_pipe && (column_count == target_column);

  always_comb begin
    pattern_sel = 8'h00;
    for (int k = 0; k < drfe_pkg::PATTERN_BYTES; k++) begin
      if (int'(field_byte_count) == k) begin
        pattern_sel = pattern_all[8*k +: 8];
      end
    end
  end

  always_comb begin
    skipping_row_next = skipping_row;
    column_count_next = column_count;
    key_accumulator_next = key_accumulator;
    value_accumulator_next = value_accumulator;
    field_byte_count_next = field_byte_count;
    still_matching_next = still_matching;
    digit_error_next = digit_error;
    if (accept) begin
      if (skipping_row || (!is_pipe && is_newline)) begin
        if (is_newline) begin
          skipping_row_next = 1'b0;
          column_count_next = 4'd0;
          key_accumulator_next = 32'd0;
          value_accumulator_next = 32'd0;
          field_byte_count_next = '0;
          still_matching_next = 1'b1;
          digit_error_next = 1'b0;
        end
      end else if (is_pipe) begin
        if (column_count == target_column) begin
          skipping_row_next = 1'b1;
        end else begin
          column_count_next = column_count + 4'd1;
        end
      end else begin
        if (column_count == 4'd0) begin
          key_accumulator_next = {key_accumulator[28:0], 3'b000}
                               + {key_accumulator[30:0], 1'b0}
                               + {24'd0, data_byte} - 32'd48;
        end
        if (column_count == target_column) begin
          if (is_digit) begin
            value_accumulator_next = {value_accumulator[28:0], 3'b000}
                                   + {value_accumulator[30:0], 1'b0}
                                   + {24'd0, digit};
          end else begin
            digit_error_next = 1'b1;
          end
          if ((field_byte_count >= len_eff) || (data_byte != pattern_sel)) begin
            still_matching_next = 1'b0;
          end
          if (int'(field_byte_count) < MAX_TEXT_BYTES + 1) begin
            field_byte_count_next = field_byte_count + CW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target_column <= drfe_pkg::TARGET_COLUMN_RESET;
      field_mode <= 1'b0;
      pattern_low_bytes <= 64'd0;
      pattern_high_bytes <= 16'd0;
      pattern_length <= 4'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        drfe_pkg::REG_TARGET_COLUMN: target_column <= cfg_data[3:0];
        drfe_pkg::REG_FIELD_MODE: field_mode <= cfg_data[0];
        drfe_pkg::REG_PATTERN_LOW: pattern_low_bytes <= cfg_data;
        drfe_pkg::REG_PATTERN_HIGH: pattern_high_bytes <= cfg_data[15:0];
        drfe_pkg::REG_PATTERN_LENGTH: pattern_length <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      skipping_row <= 1'b0;
      column_count <= 4'd0;
      key_accumulator <= 32'd0;
      value_accumulator <= 32'd0;
      field_byte_count <= '0;
      still_matching <= 1'b1;
      digit_error <= 1'b0;
    end else begin
      skipping_row <= skipping_row_next;
      column_count <= column_count_next;
      key_accumulator <= key_accumulator_next;
      value_accumulator <= value_accumulator_next;
      field_byte_count <= field_byte_count_next;
      still_matching <= still_matching_next;
      digit_error <= digit_error_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      row_key <= key_accumulator;
      field_value <= field_mode ? 32'd0 : value_accumulator;
      text_match <= field_mode && still_matching && (field_byte_count == len_eff);
      bad_digit <= !field_mode && digit_error;
    end
  end

`ifndef NO_ASSERTIONS
  a_emit_starts_skip: assert property (@(posedge clk) disable iff (rst)
    emit |=> skipping_row)
    else $error("Row was not skipped after its result beat.");

  a_full_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("Input accepted while the result register is full and stalled.");

  a_no_emit_while_skipping: assert property (@(posedge clk) disable iff (rst)
    skipping_row |-> !emit)
    else $error("Result beat emitted during a skipped row.");

  a_byte_count_saturates: assert property (@(posedge clk) disable iff (rst)
    int'(field_byte_count) <= MAX_TEXT_BYTES + 1)
    else $error("Field byte count passed its saturation limit.");

  a_mode_exclusive: assert property (@(posedge clk) disable iff (rst)
    (out_valid && text_match) |-> (!bad_digit && (field_value == 32'd0)))
    else $error("Text match reported together with numeric results.");
`endif

endmodule

[tb/testbench.sv]
// Self-checking testbench for the delimited row field extractor with a row parser predictor.
`timescale 1ns / 1ps

module testbench;

  localparam logic MODE_NUMERIC = 1'b0;
  localparam logic MODE_TEXT = 1'b1;
  localparam int TEXT_MAX = drfe_pkg::MAX_TEXT_BYTES_DEFAULT;
  localparam int PHASES = 12;
  localparam int BYTES_PER_PHASE = 170;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic [31:0] key_val;
    logic [31:0] field_val;
    logic        text_hit;
    logic        bad;
  } row_result_t;

  logic                                 clk = 1'b0;
  logic                                 rst = 1'b1;
  logic                                 cfg_we = 1'b0;
  logic [drfe_pkg::CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [drfe_pkg::CFG_DATA_WIDTH-1:0]  cfg_data = '0;
  logic                                 in_valid = 1'b0;
  logic                                 in_ready;
  logic [7:0]                           data_byte = 8'h00;
  logic                                 out_valid;
  logic                                 out_ready = 1'b0;
  logic [31:0]                          row_key;
  logic [31:0]                          field_value;
  logic                                 text_match;
  logic                                 bad_digit;

  delimited_row_field_extract_top dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .data_byte(data_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .row_key(row_key),
    .field_value(field_value),
    .text_match(text_match),
    .bad_digit(bad_digit)
  );

  always #4 clk = ~clk;

  // Mirror of the registers and the row state.
  logic [3:0]  tgt_q = drfe_pkg::TARGET_COLUMN_RESET;
  logic        mode_q = MODE_NUMERIC;
  logic [63:0] pat_lo_q = '0;
  logic [15:0] pat_hi_q = '0;
  logic [3:0]  pat_len_q = '0;
  logic        skip_q = 1'b0;
  logic [3:0]  col_q = '0;
  logic [31:0] key_q = '0;
  logic [31:0] val_q = '0;
  logic [3:0]  fbc_q = '0;
  logic        match_q = 1'b1;
  logic        derr_q = 1'b0;

  row_result_t expected_rows[$];
  logic [7:0]  bytes_pending[$];
  int          bytes_pushed = 0;
  int          bytes_accepted = 0;
  int          results_seen = 0;
  int          mismatches = 0;
  int          idle_cycles = 0;
  bit          byte_taken = 1'b0;
  int          burst_left = 0;
  int          gap_left = 0;
  int          rx_tick = 0;
  int          rx_mode = 0;
  int          hold_left = 0;
  bit          held_once = 1'b0;

  function automatic void clear_row();
    skip_q = 1'b0;
    col_q = '0;
    key_q = '0;
    val_q = '0;
    fbc_q = '0;
    match_q = 1'b1;
    derr_q = 1'b0;
  endfunction

  function automatic logic [7:0] pattern_at(input int unsigned pos);
    if (pos < 8) return pat_lo_q[8*pos +: 8];
    if (pos < 10) return pat_hi_q[8*(pos-8) +: 8];
    return 8'h00;
  endfunction

  function automatic int unsigned text_len();
    return (pat_len_q > TEXT_MAX) ? TEXT_MAX : pat_len_q;
  endfunction

  function automatic void parse_byte(input logic [7:0] b);
    logic [31:0] d;
    int unsigned n;
    row_result_t r;
    d = {24'd0, b} - 32'd48;
    n = text_len();
    if (skip_q) begin
      if (b == drfe_pkg::NEWLINE_BYTE) clear_row();
      return;
    end
    if (col_q == 0 && b != drfe_pkg::PIPE_BYTE) key_q = key_q * 32'd10 + d;
    if (b == drfe_pkg::PIPE_BYTE) begin
      if (col_q == tgt_q) begin
        r.key_val = key_q;
        r.field_val = (mode_q == MODE_NUMERIC) ? val_q : 32'd0;
        r.text_hit = (mode_q == MODE_TEXT) && match_q && (fbc_q == n);
        r.bad = (mode_q == MODE_NUMERIC) && derr_q;
        expected_rows.insert(expected_rows.size(), r);
        skip_q = 1'b1;
      end else begin
        col_q = col_q + 4'd1;
      end
      return;
    end
    if (b == drfe_pkg::NEWLINE_BYTE) begin
      clear_row();
      return;
    end
    if (col_q == tgt_q) begin
      if (d > 32'd9) derr_q = 1'b1;
      else val_q = val_q * 32'd10 + d;
      if (fbc_q >= n || b != pattern_at(fbc_q)) match_q = 1'b0;
      if (fbc_q < TEXT_MAX + 1) fbc_q = fbc_q + 4'd1;
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < 40)
      $display("MISMATCH result %0d %s: got %0h, expected %0h", results_seen, what, got, want);
    mismatches++;
  endtask

  // Result checking, prediction of accepted bytes and the watchdog.
  always @(posedge clk) begin
    row_result_t exp_row;
    if (!rst) begin
      idle_cycles++;
      if (out_valid && out_ready) begin
        idle_cycles = 0;
        if (expected_rows.size() == 0) begin
          report_mismatch("unexpected beat, row_key", row_key, 32'd0);
        end else begin
          exp_row = expected_rows.pop_front();
          if (row_key !== exp_row.key_val) report_mismatch("row_key", row_key, exp_row.key_val);
          if (field_value !== exp_row.field_val)
            report_mismatch("field_value", field_value, exp_row.field_val);
          if (text_match !== exp_row.text_hit)
            report_mismatch("text_match", text_match, exp_row.text_hit);
          if (bad_digit !== exp_row.bad) report_mismatch("bad_digit", bad_digit, exp_row.bad);
        end
        results_seen++;
      end
      if (in_valid && in_ready) begin
        idle_cycles = 0;
        bytes_accepted++;
        parse_byte(data_byte);
        byte_taken = 1'b1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Byte sender: bursts of random length separated by random gaps.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || byte_taken) begin
      byte_taken = 1'b0;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 48);
        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
      end
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (bytes_pending.size() > 0) begin
        in_valid <= 1'b1;
        data_byte <= bytes_pending.pop_front();
        burst_left--;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result receiver with changing stall patterns and one long hold-off.
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      rx_tick++;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!held_once && results_seen >= 40) begin
        held_once = 1'b1;
        hold_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        if (rx_tick % 200 == 0) rx_mode = $urandom_range(0, 3);
        case (rx_mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 1) == 1);
          2: out_ready <= (rx_tick % 4 != 0);
          default: out_ready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  task automatic push_byte(input logic [7:0] b);
    bytes_pending.insert(bytes_pending.size(), b);
    bytes_pushed++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    while (b == drfe_pkg::PIPE_BYTE || b == drfe_pkg::NEWLINE_BYTE)
      b = 8'($urandom_range(0, 255));
    return b;
  endfunction

  function automatic logic [7:0] digit_byte();
    return 8'(drfe_pkg::ZERO_BYTE + $urandom_range(0, 9));
  endfunction

  task automatic push_key();
    int unsigned n;
    n = $urandom_range(0, 11);
    repeat (n) push_byte(($urandom_range(0, 15) == 0) ? plain_byte() : digit_byte());
  endtask

  task automatic push_target_field();
    int unsigned n;
    int unsigned sel;
    int unsigned odd_pos;
    n = text_len();
    if (mode_q == MODE_NUMERIC) begin
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 14) : $urandom_range(0, 6);
      odd_pos = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 14) : 99;
      for (int i = 0; i < n; i++) push_byte((i == odd_pos) ? plain_byte() : digit_byte());
    end else begin
      sel = $urandom_range(0, 5);
      odd_pos = (n > 0) ? $urandom_range(0, n - 1) : 0;
      case (sel)
        2: for (int i = 0; i + 1 < n; i++) push_byte(pattern_at(i));
        3: begin
          for (int i = 0; i < n; i++) push_byte(pattern_at(i));
          push_byte(plain_byte());
        end
        4: for (int i = 0; i < n; i++) push_byte((i == odd_pos) ? plain_byte() : pattern_at(i));
        5: repeat ($urandom_range(0, 13)) push_byte(plain_byte());
        default: for (int i = 0; i < n; i++) push_byte(pattern_at(i));
      endcase
    end
  endtask

  task automatic push_random_row();
    int unsigned kind;
    int cut;
    kind = $urandom_range(0, 19);
    if (kind == 0) begin
      repeat ($urandom_range(1, 24)) push_byte(8'($urandom_range(0, 255)));
      push_byte(drfe_pkg::NEWLINE_BYTE);
      return;
    end
    cut = (kind == 1) ? $urandom_range(0, tgt_q) : 16;
    for (int c = 0; c <= tgt_q; c++) begin
      if (c > 0) push_byte(drfe_pkg::PIPE_BYTE);
      if (c == tgt_q) push_target_field();
      else if (c == 0) push_key();
      else repeat ($urandom_range(0, 5)) push_byte(plain_byte());
      if (c == cut) begin
        push_byte(drfe_pkg::NEWLINE_BYTE);
        return;
      end
    end
    push_byte(drfe_pkg::PIPE_BYTE);
    repeat ($urandom_range(0, 8))
      push_byte(($urandom_range(0, 5) == 0) ? drfe_pkg::PIPE_BYTE : plain_byte());
    push_byte(drfe_pkg::NEWLINE_BYTE);
  endtask

  task automatic write_reg(input logic [drfe_pkg::CFG_INDEX_WIDTH-1:0] idx,
                           input logic [63:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      drfe_pkg::REG_TARGET_COLUMN: tgt_q = val[3:0];
      drfe_pkg::REG_FIELD_MODE: mode_q = val[0];
      drfe_pkg::REG_PATTERN_LOW: pat_lo_q = val;
      drfe_pkg::REG_PATTERN_HIGH: pat_hi_q = val[15:0];
      drfe_pkg::REG_PATTERN_LENGTH: pat_len_q = val[3:0];
      default: ;
    endcase
  endtask

  function automatic logic [7:0] pattern_pick();
    return ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(97, 122));
  endfunction

  task automatic configure_phase(input int p);
    logic [3:0]  col;
    logic        mode;
    logic [63:0] lo;
    logic [15:0] hi;
    logic [3:0]  len;
    case (p)
      1: begin
        col = 4'd2; mode = MODE_TEXT; lo = 64'h636261; hi = '0; len = 4'd3;
      end
      2: begin
        col = 4'd1; mode = MODE_TEXT; lo = 64'h3736353433323130; hi = 16'h3938; len = 4'd15;
      end
      3: begin
        col = 4'd0; mode = MODE_NUMERIC; lo = '0; hi = '0; len = 4'd0;
      end
      4: begin
        col = 4'd15; mode = MODE_TEXT; lo = '1; hi = '1; len = 4'd0;
      end
      5: begin
        col = 4'd3; mode = MODE_TEXT; lo = '1; hi = '1; len = 4'd10;
      end
      default: begin
        col = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(1, 4));
        mode = 1'($urandom_range(0, 1));
        for (int i = 0; i < 8; i++) lo[8*i +: 8] = pattern_pick();
        hi = {pattern_pick(), pattern_pick()};
        len = 4'($urandom_range(0, 15));
      end
    endcase
    write_reg(drfe_pkg::REG_TARGET_COLUMN, 64'(col));
    write_reg(drfe_pkg::REG_FIELD_MODE, 64'(mode));
    write_reg(drfe_pkg::REG_PATTERN_LOW, lo);
    write_reg(drfe_pkg::REG_PATTERN_HIGH, 64'(hi));
    write_reg(drfe_pkg::REG_PATTERN_LENGTH, 64'(len));
  endtask

  task automatic wait_drained();
    while (bytes_accepted != bytes_pushed || expected_rows.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  initial begin
    clear_row();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        wait_drained();
        configure_phase(p);
      end
      case (p)
        0: begin
          push_text("4294967295|4294967299|\n");
          push_text("A|4x2|\n");
          push_text("12\n");
          push_text("|\n");
          push_byte(8'hFF);
          push_byte(8'h00);
          push_text("|9|\n");
        end
        1: begin
          push_text("1|x|abc|\n");
          push_text("2||abcd|\n");
          push_text("3|x|ab|q\n");
        end
        2: begin
          push_text("9|0123456789|\n");
          push_text("8|01234567890|\n");
        end
        3: begin
          push_text("123|\n");
          push_text("5x|\n");
        end
        default: ;
      endcase
      while (bytes_pushed < (p + 1) * BYTES_PER_PHASE) push_random_row();
      // An unfinished row now and then, so the next settings apply within a row.
      if ($urandom_range(0, 2) == 0) begin
        push_key();
        push_byte(drfe_pkg::PIPE_BYTE);
      end
    end
    wait_drained();
    repeat (8) @(negedge clk);
    if (mismatches == 0 && expected_rows.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
